[rtl/plcj_pkg.sv]
// ----------------------------------------------------------------------------
// plcj_pkg: shared types and constants for the point link constraint jacobian
// fixed point formats, trig polynomial coefficients, register indexes
// ----------------------------------------------------------------------------
package plcj_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int GAIN_W        = 31;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_AX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_AY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_AX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_AY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPER    = 3'd5;

  localparam logic [30:0] TRIG_ONE = 31'd1073741824;
  localparam logic [30:0] TRIG_A1  = 31'd1686629713;
  localparam logic [30:0] TRIG_A3  = 31'd693598668;
  localparam logic [30:0] TRIG_A5  = 31'd85569306;
  localparam logic [30:0] TRIG_A7  = 31'd5026996;
  localparam logic [30:0] TRIG_A9  = 31'd172272;

  typedef struct packed {
    logic signed [WORD_W-1:0] first_pos_x;
    logic signed [WORD_W-1:0] first_pos_y;
    logic        [WORD_W-1:0] first_angle;
    logic signed [WORD_W-1:0] first_spin;
    logic signed [WORD_W-1:0] second_pos_x;
    logic signed [WORD_W-1:0] second_pos_y;
    logic        [WORD_W-1:0] second_angle;
    logic signed [WORD_W-1:0] second_spin;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] error_x;
    logic signed [WORD_W-1:0] error_y;
    logic signed [WORD_W-1:0] jac_first_row0;
    logic signed [WORD_W-1:0] jac_first_row1;
    logic signed [WORD_W-1:0] jac_second_row0;
    logic signed [WORD_W-1:0] jac_second_row1;
    logic signed [WORD_W-1:0] rate_first_row0;
    logic signed [WORD_W-1:0] rate_first_row1;
    logic signed [WORD_W-1:0] rate_second_row0;
    logic signed [WORD_W-1:0] rate_second_row1;
    logic        [GAIN_W-1:0] spring_out;
    logic        [GAIN_W-1:0] damper_out;
  } out_word_t;

  // pipeline step control
  typedef struct packed {
    logic adv;
    logic vld;
  } stg_ctl_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [40:0] v);
    logic signed [40:0] hi;
    logic signed [40:0] lo;
    hi = 41'sd2147483647;
    lo = -41'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[WORD_W-1:0];
  endfunction

endpackage

[rtl/plcj_if.sv]
// ----------------------------------------------------------------------------
// plcj_if: valid/ready channel carrying one word
// source drives valid and payload, sink drives ready
// ----------------------------------------------------------------------------
interface plcj_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/plcj_step.sv]
// ----------------------------------------------------------------------------
// plcj_step: one stage of polynomial step p' = k - (p * z2 >> 30)
// registered, advances with the shared pipeline enable
// ----------------------------------------------------------------------------
module plcj_step (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] coef,
  input  logic [30:0] p_in,
  input  logic [30:0] z2_in,
  output logic [30:0] p_out
);
  logic [61:0] prod;
  logic [30:0] p_r;

  assign prod  = p_in * z2_in;
  assign p_out = p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= coef - prod[60:30];
    end
  end
endmodule

[rtl/plcj_sine.sv]
// ----------------------------------------------------------------------------
// plcj_sine: pipelined binary angle sine, signed Q2.30
// quadrant fold, z squared, four horner steps, final multiply and clamp
// advances with en
// ----------------------------------------------------------------------------
module plcj_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        angle,
  output logic signed [31:0] sine
);
  import plcj_pkg::*;

  localparam int LAT = 7;

  logic [30:0] z_r [LAT-1];
  logic [30:0] z2_r [1:LAT-3];
  logic        neg_r [LAT-1];
  logic [30:0] z_fold;
  logic [61:0] zz;
  logic [30:0] p1, p2, p3, p4;
  logic [61:0] fin;
  logic [30:0] mag;
  logic signed [31:0] sine_r;

  assign z_fold = angle[30] ? (TRIG_ONE - {1'b0, angle[29:0]}) : {1'b0, angle[29:0]};
  assign zz = z_r[0] * z_r[0];

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= z_fold;
      neg_r[0] <= angle[31];
      z2_r[1]  <= zz[60:30];
      z_r[1]   <= z_r[0];
      neg_r[1] <= neg_r[0];
      for (int i = 2; i < LAT - 1; i++) begin
        z_r[i] <= z_r[i-1];
      end
      for (int i = 2; i < LAT - 2; i++) begin
        z2_r[i] <= z2_r[i-1];
      end
      for (int i = 2; i < LAT - 1; i++) begin
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  // horner chain, one step per stage
  plcj_step u_s7 (.clk, .en, .coef(TRIG_A7), .p_in(TRIG_A9), .z2_in(z2_r[1]), .p_out(p1));
  plcj_step u_s5 (.clk, .en, .coef(TRIG_A5), .p_in(p1), .z2_in(z2_r[2]), .p_out(p2));
  plcj_step u_s3 (.clk, .en, .coef(TRIG_A3), .p_in(p2), .z2_in(z2_r[3]), .p_out(p3));
  plcj_step u_s1 (.clk, .en, .coef(TRIG_A1), .p_in(p3), .z2_in(z2_r[4]), .p_out(p4));

  assign fin = p4 * z_r[5];
  assign mag = (fin[61:30] > {1'b0, TRIG_ONE}) ? TRIG_ONE : fin[60:30];

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r <= neg_r[LAT-2] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sine = sine_r;
endmodule

[rtl/plcj_body.sv]
// ----------------------------------------------------------------------------
// plcj_body: rotate one anchor and form its rate terms
// sine/cosine pipes, products, rounding and clamp, rate multiply
// ----------------------------------------------------------------------------
module plcj_body #(
  parameter int FRAC_BITS = plcj_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        angle,
  input  logic signed [31:0] spin,
  input  logic signed [31:0] anc_x,
  input  logic signed [31:0] anc_y,
  output logic signed [33:0] rot_x,
  output logic signed [33:0] rot_y,
  output logic signed [40:0] rate_x,
  output logic signed [40:0] rate_y
);
  import plcj_pkg::*;

  // spin waits for the sine, product and round stages
  localparam int SLAT = 9;
  localparam logic signed [33:0] LIM = 34'sd4294967295;

  logic signed [31:0] s, c;
  logic signed [31:0] w_r [SLAT];
  logic signed [63:0] cx_r, sy_r, sx_r, cy_r;
  logic signed [65:0] rx_sum, ry_sum;
  logic signed [35:0] rx_sh, ry_sh;
  logic signed [33:0] rx_r, ry_r, rx2_r, ry2_r;
  logic signed [66:0] wx, wy;
  logic signed [66:0] wx_r, wy_r;
  logic signed [66:0] wx_sh, wy_sh;

  plcj_sine u_sin (.clk, .en, .angle(angle), .sine(s));
  plcj_sine u_cos (.clk, .en, .angle(angle + 32'h4000_0000), .sine(c));

  assign rx_sum = 66'(cx_r) - 66'(sy_r) + 66'sd536870912;
  assign ry_sum = 66'(sx_r) + 66'(cy_r) + 66'sd536870912;
  assign rx_sh  = 36'(rx_sum >>> 30);
  assign ry_sh  = 36'(ry_sum >>> 30);

  assign wx = 67'(w_r[SLAT-1]) * 67'(rx_r);
  assign wy = 67'(w_r[SLAT-1]) * 67'(ry_r);
  assign wx_sh = (wx_r + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign wy_sh = (wy_r + (67'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= spin;
      for (int i = 1; i < SLAT; i++) w_r[i] <= w_r[i-1];
      // products
      cx_r <= c * anc_x;
      sy_r <= s * anc_y;
      sx_r <= s * anc_x;
      cy_r <= c * anc_y;
      // round and clamp
      rx_r <= (rx_sh > 36'(LIM)) ? LIM : ((rx_sh < -36'(LIM)) ? -LIM : rx_sh[33:0]);
      ry_r <= (ry_sh > 36'(LIM)) ? LIM : ((ry_sh < -36'(LIM)) ? -LIM : ry_sh[33:0]);
      // rate multiply
      wx_r  <= wx;
      wy_r  <= wy;
      rx2_r <= rx_r;
      ry2_r <= ry_r;
    end
  end

  assign rot_x  = rx2_r;
  assign rot_y  = ry2_r;
  // rate values beyond +/-2^32 saturate, keep sign and clamp range
  assign rate_x = (wx_sh > 67'sd4294967296) ? 41'sd4294967296 :
                  ((wx_sh < -67'sd4294967296) ? -41'sd4294967296 : wx_sh[40:0]);
  assign rate_y = (wy_sh > 67'sd4294967296) ? 41'sd4294967296 :
                  ((wy_sh < -67'sd4294967296) ? -41'sd4294967296 : wy_sh[40:0]);
endmodule

[rtl/point_link_constraint_jacobian_top.sv]
// ----------------------------------------------------------------------------
// point_link_constraint_jacobian_top: planar pin joint jacobian pipeline
// rotates both anchors, forms position error, jacobian angle columns,
// their derivatives, and echoes the gains
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  in_     | in  | in_ch valid/ready    | positions, angles, spins of both bodies
//  out_    | out | out_ch valid/ready   | error, jacobian and rate columns, gains
//  cfg_    | in  | cfg_we, no wait      | anchors and gains, index 0..5
//
// one word per cycle while the output is not stalled; the delay from accept
// to out valid is set by the sine pipeline, product, round, rate multiply and output stages
// the whole pipeline advances together whenever the output register is free
// or being taken, so a stall freezes every stage and nothing is lost
// reset clears the valid bits and returns the config registers to their reset values
module point_link_constraint_jacobian_top #(
  parameter int FRAC_BITS = plcj_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  plcj_if.sink                                in_ch,
  plcj_if.source                              out_ch,
  input  logic                                cfg_we,
  input  logic [plcj_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [plcj_pkg::WORD_W-1:0]         cfg_data
);
  import plcj_pkg::*;

  localparam int LAT = 11;

  logic signed [31:0] fax_r, fay_r, sax_r, say_r;
  logic [GAIN_W-1:0]  spring_r, damper_r;
  logic [LAT-1:0]     vld_r;
  stg_ctl_t           ctl;
  in_word_t           iw;
  in_word_t           dly_r [LAT-1];
  logic signed [33:0] r1x, r1y, r2x, r2y;
  logic signed [40:0] q1x, q1y, q2x, q2y;
  out_word_t          ow_nxt, ow_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fax_r <= '0;
      fay_r <= '0;
      sax_r <= '0;
      say_r <= '0;
      spring_r <= GAIN_W'(20 << FRAC_BITS);
      damper_r <= GAIN_W'(2 << FRAC_BITS);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FIRST_AX:  fax_r <= cfg_data;
        REG_FIRST_AY:  fay_r <= cfg_data;
        REG_SECOND_AX: sax_r <= cfg_data;
        REG_SECOND_AY: say_r <= cfg_data;
        REG_SPRING:    spring_r <= cfg_data[GAIN_W-1:0];
        REG_DAMPER:    damper_r <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: output slot empty or taken this cycle
  assign ctl.adv = !vld_r[LAT-1] || out_ch.ready;
  assign ctl.vld = in_ch.valid;
  assign in_ch.ready = ctl.adv;
  assign iw = in_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.adv) begin
      vld_r <= {vld_r[LAT-2:0], ctl.vld};
    end
  end

  // positions ride alongside the math
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      dly_r[0] <= iw;
      for (int i = 1; i < LAT - 1; i++) dly_r[i] <= dly_r[i-1];
    end
  end

  plcj_body #(.FRAC_BITS(FRAC_BITS)) u_first (
    .clk, .en(ctl.adv), .angle(iw.first_angle), .spin(iw.first_spin),
    .anc_x(fax_r), .anc_y(fay_r), .rot_x(r1x), .rot_y(r1y), .rate_x(q1x), .rate_y(q1y)
  );
  plcj_body #(.FRAC_BITS(FRAC_BITS)) u_second (
    .clk, .en(ctl.adv), .angle(iw.second_angle), .spin(iw.second_spin),
    .anc_x(sax_r), .anc_y(say_r), .rot_x(r2x), .rot_y(r2y), .rate_x(q2x), .rate_y(q2y)
  );

  // final combine and saturate
  always_comb begin
    in_word_t d;
    d = dly_r[LAT-2];
    ow_nxt.error_x = sat32(41'(d.first_pos_x) + 41'(r1x) - 41'(d.second_pos_x) - 41'(r2x));
    ow_nxt.error_y = sat32(41'(d.first_pos_y) + 41'(r1y) - 41'(d.second_pos_y) - 41'(r2y));
    ow_nxt.jac_first_row0   = sat32(-41'(r1y));
    ow_nxt.jac_first_row1   = sat32(41'(r1x));
    ow_nxt.jac_second_row0  = sat32(41'(r2y));
    ow_nxt.jac_second_row1  = sat32(-41'(r2x));
    ow_nxt.rate_first_row0  = sat32(-q1x);
    ow_nxt.rate_first_row1  = sat32(-q1y);
    ow_nxt.rate_second_row0 = sat32(q2x);
    ow_nxt.rate_second_row1 = sat32(q2y);
    ow_nxt.spring_out = spring_r;
    ow_nxt.damper_out = damper_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) ow_r <= ow_nxt;
  end

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.data  = ow_r;

  // a held output freezes the whole pipe
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(vld_r) && $stable(ow_r))
    else $error("pipe moved under stall");
  // input ready follows output slot
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken under stall");
  // accepted word reaches the tap one step on
  a_vld0: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("valid bit lost");
endmodule
